// ===== rtl/page_frame_translate_replace_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PAGE_FRAME_TRANSLATE_REPLACE_DEFINES_SVH
`define PAGE_FRAME_TRANSLATE_REPLACE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFR_ASSERT_NOW(label, clk, rstn, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFR_ASSERT_NEXT(label, clk, rstn, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfr_pkg.sv =====
package pfr_pkg;

    localparam int DATA_W         = 32;
    localparam int PAGE_W         = 31;
    localparam int CFG_W          = 5;
    localparam int ADDR_W         = 4;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int AGE_WIDTH_DEF  = 32;

    localparam logic [CFG_W-1:0] PAGE_BITS_RST   = 5'd12;
    localparam logic [CFG_W-1:0] VADDR_BITS_RST  = 5'd16;
    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd16;
    localparam logic             LRU_MODE_RST    = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PAGE_BITS   = 2'd0;
    localparam logic [1:0] REG_VADDR_BITS  = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd2;
    localparam logic [1:0] REG_LRU_MODE    = 2'd3;

    // Search record flowing down the cell chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              free_found;
        logic [PAGE_W-1:0] page;
    } scan_ctl_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic              age_en;
        logic              clr_age;
        logic              load;
        logic [PAGE_W-1:0] page;
    } upd_cmd_t;

endpackage

// ===== rtl/pfr_cell.sv =====
module pfr_cell import pfr_pkg::*; #(
    parameter int IDX        = 0,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int AGE_WIDTH  = AGE_WIDTH_DEF,
    localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_use,
    input  upd_cmd_t             cmd,
    input  logic [IDX_W-1:0]     slot,
    input  scan_ctl_t            rec_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     free_idx_in,
    input  logic [IDX_W-1:0]     best_idx_in,
    input  logic [AGE_WIDTH-1:0] best_age_in,
    output scan_ctl_t            rec_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     free_idx_out,
    output logic [IDX_W-1:0]     best_idx_out,
    output logic [AGE_WIDTH-1:0] best_age_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [PAGE_W-1:0]    page_reg;
    logic                 valid_reg;
    logic [AGE_WIDTH-1:0] age_reg;

    scan_ctl_t            rec_reg, rec_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [AGE_WIDTH-1:0] best_age_reg, best_age_next;

    logic sel;

    assign sel = (slot == MY_IDX);

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end else begin
            if (cmd.load && sel) begin
                valid_reg <= 1'b1;
                age_reg   <= '0;
            end else if (cmd.clr_age && sel) begin
                age_reg <= '0;
            end else if (cmd.age_en && in_use && valid_reg && !(&age_reg)) begin
                age_reg <= age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && sel) begin
            page_reg <= cmd.page;
        end
    end

    // Fold this frame into the search record
    always_comb begin
        rec_next      = rec_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        best_idx_next = best_idx_in;
        best_age_next = best_age_in;
        if (in_use) begin
            if (!rec_in.found && valid_reg && (page_reg == rec_in.page)) begin
                rec_next.found = 1'b1;
                hit_idx_next   = MY_IDX;
            end
            if (!rec_in.free_found && !valid_reg) begin
                rec_next.free_found = 1'b1;
                free_idx_next       = MY_IDX;
            end
            // strict compare keeps the lowest index on ties
            if (valid_reg && (age_reg > best_age_in)) begin
                best_idx_next = MY_IDX;
                best_age_next = age_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
    end

    assign rec_out      = rec_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign best_idx_out = best_idx_reg;
    assign best_age_out = best_age_reg;

endmodule

// ===== rtl/page_frame_translate_replace.sv =====
// An in-range address is launched down the frame chain, each frame registering the search
// record; the finished record is latched, then the frames are updated and the result loaded.
// Out-of-range addresses go straight to the finish state and touch no frame.
// A new input is taken only after the result is loaded; a stalled result holds it off.
// Reset: synchronous, active low; clears all frames, ages, the eviction count and the
// result channel, and loads the register defaults.
module page_frame_translate_replace import pfr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_virt_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_phys_address,
    output logic              m_out_of_range,
    output logic              m_hit,
    output logic              m_evicted,
    output logic [DATA_W-1:0] m_swap_total
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [CFG_W-1:0] page_bits_reg, vaddr_bits_reg, frame_count_reg;
    logic             lru_mode_reg;

    logic [DATA_W-1:0] addr_reg;
    logic              oor_reg;
    logic [DATA_W-1:0] count_reg;

    logic              res_found_reg, res_free_reg;
    logic [IDX_W-1:0]  res_hit_reg, res_free_idx_reg, res_best_reg;

    logic [DATA_W-1:0] m_phys_reg, m_swap_reg;
    logic              m_valid_reg, m_oor_reg, m_hit_reg, m_evicted_reg;

    logic              accept, oor_in, fin_go, evict;
    logic              cfg_wr;
    logic [PAGE_W-1:0] page_w;
    logic [DATA_W-1:0] offset_w, phys_w, count_inc;
    logic [IDX_W-1:0]  slot_sel;
    upd_cmd_t          cmd;

    scan_ctl_t            rec_chain  [0:MAX_FRAMES];
    logic [IDX_W-1:0]     hit_chain  [0:MAX_FRAMES];
    logic [IDX_W-1:0]     free_chain [0:MAX_FRAMES];
    logic [IDX_W-1:0]     best_chain [0:MAX_FRAMES];
    logic [AGE_WIDTH-1:0] age_chain  [0:MAX_FRAMES];
    logic [MAX_FRAMES-1:0] in_use;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bits_reg   <= PAGE_BITS_RST;
            vaddr_bits_reg  <= VADDR_BITS_RST;
            frame_count_reg <= FRAME_COUNT_RST;
            lru_mode_reg    <= LRU_MODE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PAGE_BITS:   page_bits_reg   <= pwdata[CFG_W-1:0];
                REG_VADDR_BITS:  vaddr_bits_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_COUNT: frame_count_reg <= pwdata[CFG_W-1:0];
                REG_LRU_MODE:    lru_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PAGE_BITS:   prdata = {{(DATA_W-CFG_W){1'b0}}, page_bits_reg};
            REG_VADDR_BITS:  prdata = {{(DATA_W-CFG_W){1'b0}}, vaddr_bits_reg};
            REG_FRAME_COUNT: prdata = {{(DATA_W-CFG_W){1'b0}}, frame_count_reg};
            REG_LRU_MODE:    prdata = {{(DATA_W-1){1'b0}}, lru_mode_reg};
            default:         prdata = '0;
        endcase
    end

    // Control
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign oor_in   = ((s_virt_address >> vaddr_bits_reg) != '0);
    assign fin_go   = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = oor_in ? S_FINISH : S_LAUNCH;
            S_LAUNCH: state_next = S_SCAN;
            S_SCAN:   if (rec_chain[MAX_FRAMES].valid) state_next = S_FINISH;
            S_FINISH: if (fin_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_virt_address;
            oor_reg  <= oor_in;
        end
    end

    // Latch the finished search record from the end of the chain
    always_ff @(posedge aclk) begin
        if ((state_reg == S_SCAN) && rec_chain[MAX_FRAMES].valid) begin
            res_found_reg    <= rec_chain[MAX_FRAMES].found;
            res_free_reg     <= rec_chain[MAX_FRAMES].free_found;
            res_hit_reg      <= hit_chain[MAX_FRAMES];
            res_free_idx_reg <= free_chain[MAX_FRAMES];
            res_best_reg     <= best_chain[MAX_FRAMES];
        end
    end

    assign page_w   = PAGE_W'(addr_reg >> page_bits_reg);
    assign offset_w = addr_reg & ~({DATA_W{1'b1}} << page_bits_reg);
    assign evict    = !res_found_reg && !res_free_reg;

    always_comb begin
        priority if (res_found_reg) begin
            slot_sel = res_hit_reg;
        end else if (res_free_reg) begin
            slot_sel = res_free_idx_reg;
        end else begin
            slot_sel = res_best_reg;
        end
    end

    assign phys_w    = (DATA_W'(slot_sel) << page_bits_reg) + offset_w;
    assign count_inc = count_reg + 1'b1;

    assign cmd.age_en  = accept && !oor_in;
    assign cmd.clr_age = fin_go && !oor_reg && res_found_reg && lru_mode_reg;
    assign cmd.load    = fin_go && !oor_reg && !res_found_reg;
    assign cmd.page    = page_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (fin_go && !oor_reg && evict) begin
            count_reg <= count_inc;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_phys_reg    <= oor_reg ? '0 : phys_w;
            m_oor_reg     <= oor_reg;
            m_hit_reg     <= !oor_reg && res_found_reg;
            m_evicted_reg <= !oor_reg && evict;
            m_swap_reg    <= (!oor_reg && evict) ? count_inc : count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_phys_address = m_phys_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_hit          = m_hit_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_swap_total   = m_swap_reg;

    // Cell chain
    assign rec_chain[0].valid      = (state_reg == S_LAUNCH);
    assign rec_chain[0].found      = 1'b0;
    assign rec_chain[0].free_found = 1'b0;
    assign rec_chain[0].page       = page_w;
    assign hit_chain[0]            = '0;
    assign free_chain[0]           = '0;
    assign best_chain[0]           = '0;
    assign age_chain[0]            = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        // frame 0 is always in use; the upper clamp follows from g < MAX_FRAMES
        assign in_use[g] = (g == 0) || ({4'd0, frame_count_reg} > 9'(g));

        pfr_cell #(
            .IDX        (g),
            .MAX_FRAMES (MAX_FRAMES),
            .AGE_WIDTH  (AGE_WIDTH)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .in_use       (in_use[g]),
            .cmd          (cmd),
            .slot         (slot_sel),
            .rec_in       (rec_chain[g]),
            .hit_idx_in   (hit_chain[g]),
            .free_idx_in  (free_chain[g]),
            .best_idx_in  (best_chain[g]),
            .best_age_in  (age_chain[g]),
            .rec_out      (rec_chain[g+1]),
            .hit_idx_out  (hit_chain[g+1]),
            .free_idx_out (free_chain[g+1]),
            .best_idx_out (best_chain[g+1]),
            .best_age_out (age_chain[g+1])
        );
    end

endmodule

// ===== rtl/pfr_checker.sv =====
`include "page_frame_translate_replace_defines.svh"

module pfr_checker import pfr_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_phys_address,
    input logic              m_out_of_range,
    input logic              m_hit,
    input logic              m_evicted,
    input logic [DATA_W-1:0] m_swap_total
);

    // Hold a stalled result with its address, swap total, hit and evicted flags
    `PFR_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_phys_address) && $stable(m_swap_total) && $stable(m_hit) && $stable(m_evicted), "result changed while stalled")

    // One item at a time: no transfer in the cycle after a transfer
    `PFR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while busy")

    `PFR_ASSERT_NOW(a_oor_clean, aclk, aresetn, m_valid && m_out_of_range, (m_phys_address == '0) && !m_hit && !m_evicted, "out-of-range result not clean")

    `PFR_ASSERT_NOW(a_hit_no_evict, aclk, aresetn, m_valid, !(m_hit && m_evicted), "hit and eviction together")

endmodule

bind page_frame_translate_replace pfr_checker u_pfr_checker (.*);
